// ----- hdl/assert_macros.svh -----
// Assertion helpers, clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/refc_pkg.sv -----
package refc_pkg;

	localparam int CH_W   = 3;
	localparam int SMP_W  = 12;
	localparam int TILT_W = 8;
	localparam int VAL_W  = 12;
	localparam int COL_W  = 3;
	localparam int AVG_W  = 20;
	localparam int THR_W  = 56;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 56;

	localparam logic [CFG_IDX_W-1:0] REG_THR_BLACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_BLUE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_RED    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR_SILVER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DSEL       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CH_COUNT   = 3'd7;

	localparam logic [COL_W-1:0] COL_UNKNOWN = 3'd0;
	localparam logic [COL_W-1:0] COL_BLACK   = 3'd1;
	localparam logic [COL_W-1:0] COL_BLUE    = 3'd2;
	localparam logic [COL_W-1:0] COL_RED     = 3'd3;
	localparam logic [COL_W-1:0] COL_SILVER  = 3'd4;

	localparam logic [VAL_W-1:0] VAL_MAX = 12'hFFF;

	localparam logic [8:0]  ALPHA_MIN   = 9'd3;
	localparam logic [8:0]  ALPHA_ONE   = 9'd256;
	localparam logic [15:0] SCALE_ONE   = 16'd256;
	localparam int          DSEL_RATIO  = 6;

	localparam int QUO_W     = 21;
	localparam int DIV_STEPS = QUO_W;

	typedef struct packed {
		logic [7:0]       tlim;
		logic [VAL_W-1:0] amax;
		logic [VAL_W-1:0] amin;
		logic [VAL_W-1:0] pmax;
		logic [VAL_W-1:0] pmin;
	} thr_t;

endpackage

// ----- hdl/refc_if.sv -----
interface refc_sample_if import refc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   channel_index;
	logic [SMP_W-1:0]  sample_value;
	logic [TILT_W-1:0] tilt_magnitude;

	modport source (output valid, output channel_index, output sample_value,
		output tilt_magnitude, input ready);
	modport sink (input valid, input channel_index, input sample_value,
		input tilt_magnitude, output ready);
endinterface

interface refc_result_if import refc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] smoothed_value;
	logic [COL_W-1:0] floor_colour;

	modport source (output valid, output smoothed_value, output floor_colour, input ready);
	modport sink (input valid, input smoothed_value, input floor_colour, output ready);
endinterface

// ----- hdl/reflectance_ema_floor_classifier_core.sv -----
// channel | dir | payload
// samp    | in  | channel_index, sample_value, tilt_magnitude
// res     | out | smoothed_value, floor_colour
// cfg     | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// Box mode steps: MUL1, MUL2, UPD, RDP, RDA, NUM, CLS, OUT; a sample on an unused
// channel skips MUL1-UPD; ratio mode adds divider setup plus 21 restoring steps.
// One shared 20x16 multiplier does the average update and the ratio numerator;
// the four colours are tested one per cycle through one shared comparator.
// samp.ready is high only while idle, from the cycle after the result is taken.
// Reset clears thresholds and seeded flags, presets other config; memory needs no clearing.
module reflectance_ema_floor_classifier_core import refc_pkg::*; #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	refc_sample_if.sink           samp,
	refc_result_if.source         res
);

	localparam int IW = $clog2(MAX_CHANNELS);
	localparam int UseBits = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
	localparam logic [SMP_W-1:0] SmpMask = SMP_W'((32'd1 << UseBits) - 32'd1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL1 = 4'd1;
	localparam logic [3:0] S_MUL2 = 4'd2;
	localparam logic [3:0] S_UPD  = 4'd3;
	localparam logic [3:0] S_RDP  = 4'd4;
	localparam logic [3:0] S_RDA  = 4'd5;
	localparam logic [3:0] S_NUM  = 4'd6;
	localparam logic [3:0] S_DSET = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_CLS  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	// configuration
	thr_t        thr_q [4];
	logic [8:0]  alpha_q;
	logic [15:0] scale_q;
	logic [6:0]  dsel_q;
	logic [3:0]  cnt_q;

	logic [8:0]  alpha_v;
	logic [15:0] scale_v;
	logic [3:0]  cnt_v;

	always_comb begin
		alpha_v = cfg_wdata[8:0];
		if (alpha_v < ALPHA_MIN) alpha_v = ALPHA_MIN;
		if (alpha_v > ALPHA_ONE) alpha_v = ALPHA_ONE;
		scale_v = cfg_wdata[15:0];
		if (scale_v < SCALE_ONE) scale_v = SCALE_ONE;
		cnt_v = cfg_wdata[3:0];
		if (cnt_v == 4'd0) cnt_v = 4'd1;
		if (cnt_v > 4'(MAX_CHANNELS)) cnt_v = 4'(MAX_CHANNELS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) thr_q[i] <= '0;
			alpha_q <= ALPHA_ONE;
			scale_q <= SCALE_ONE;
			dsel_q  <= 7'd8;
			cnt_q   <= 4'(MAX_CHANNELS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THR_BLACK:  thr_q[0] <= thr_t'(cfg_wdata[THR_W-1:0]);
				REG_THR_BLUE:   thr_q[1] <= thr_t'(cfg_wdata[THR_W-1:0]);
				REG_THR_RED:    thr_q[2] <= thr_t'(cfg_wdata[THR_W-1:0]);
				REG_THR_SILVER: thr_q[3] <= thr_t'(cfg_wdata[THR_W-1:0]);
				REG_ALPHA:      alpha_q <= alpha_v;
				REG_SCALE:      scale_q <= scale_v;
				REG_DSEL:       dsel_q <= cfg_wdata[6:0];
				REG_CH_COUNT:   cnt_q <= cnt_v;
				default: ;
			endcase
		end
	end

	// decision channels
	logic [IW-1:0] pidx, aidx;
	logic [3:0]    cnt_m1;

	always_comb begin
		cnt_m1 = cnt_q - 4'd1;
		pidx = ({1'b0, dsel_q[2:0]} < cnt_q) ? dsel_q[IW-1:0] : '0;
		aidx = ({1'b0, dsel_q[5:3]} < cnt_q) ? dsel_q[3+IW-1:3] : cnt_m1[IW-1:0];
	end

	// control and item registers
	logic [3:0]          state_q;
	logic [IW-1:0]       ch_q;
	logic                use_q;
	logic [SMP_W-1:0]    smp_q;
	logic [TILT_W-1:0]   tilt_q;
	logic [MAX_CHANNELS-1:0] seeded_q;
	logic [27:0]         prod_q, acc_q;
	logic [VAL_W-1:0]    prim_q, aux_q, div_q, smoothed_q;
	logic [VAL_W-1:0]    rem_q;
	logic [QUO_W-1:0]    dq_q;
	logic [4:0]          div_cnt_q;
	logic [1:0]          cls_q;
	logic [COL_W-1:0]    colour_q;

	// average memory
	logic [AVG_W-1:0] avg_mem [MAX_CHANNELS];
	logic [AVG_W-1:0] rd_q;
	logic [IW-1:0]    rd_addr;
	logic             mem_we;
	logic [AVG_W-1:0] new_avg;

	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = samp.channel_index[IW-1:0];
			S_RDP:   rd_addr = pidx;
			default: rd_addr = aidx;
		endcase
	end

	assign mem_we = (state_q == S_UPD);

	always_ff @(posedge clk) begin
		if (mem_we) avg_mem[ch_q] <= new_avg;
		rd_q <= avg_mem[rd_addr];
	end

	function automatic logic [VAL_W-1:0] rnd_avg(input logic [AVG_W-1:0] a);
		logic [AVG_W:0] s;
		s = {1'b0, a} + (AVG_W+1)'(128);
		return (s[AVG_W:8] > {1'b0, VAL_MAX}) ? VAL_MAX : s[AVG_W-1:8];
	endfunction

	// shared multiplier
	logic [AVG_W-1:0] mul_a;
	logic [15:0]      mul_b;
	logic [35:0]      mul_p;
	logic [8:0]       alpha_c;

	always_comb begin
		alpha_c = ALPHA_ONE - alpha_q;
		case (state_q)
			S_MUL1: begin
				mul_a = rd_q;
				mul_b = {7'd0, alpha_c};
			end
			S_MUL2: begin
				mul_a = {{(AVG_W-SMP_W){1'b0}}, smp_q};
				mul_b = {7'd0, alpha_q};
			end
			default: begin
				mul_a = {{(AVG_W-VAL_W){1'b0}}, prim_q};
				mul_b = scale_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// average update
	logic [28:0] upd_sum;
	always_comb begin
		upd_sum = {1'b0, acc_q} + {prod_q[20:0], 8'd0} + 29'd128;
		new_avg = seeded_q[ch_q] ? upd_sum[27:8] : {smp_q, 8'd0};
	end

	// divider step
	logic [VAL_W:0]   div_sh;
	logic             div_ge;
	logic [VAL_W-1:0] aux_nz;
	logic [28:0]      div_num;

	always_comb begin
		aux_nz  = (aux_q == '0) ? VAL_W'(1) : aux_q;
		div_num = {1'b0, prod_q} + {10'd0, aux_nz, 7'd0};
		div_sh  = {rem_q, dq_q[QUO_W-1]};
		div_ge  = div_sh >= {1'b0, div_q};
	end

	// colour test
	thr_t             thr_c;
	logic [VAL_W-1:0] pv;
	logic             hit;

	always_comb begin
		thr_c = thr_q[cls_q];
		if (dsel_q[DSEL_RATIO])
			pv = (dq_q > QUO_W'(VAL_MAX)) ? VAL_MAX : dq_q[VAL_W-1:0];
		else
			pv = prim_q;
		hit = !(thr_c.pmax == '0 && thr_c.amax == '0);
		if (pv < thr_c.pmin || pv > thr_c.pmax) hit = 1'b0;
		if (!dsel_q[DSEL_RATIO] && (aux_q < thr_c.amin || aux_q > thr_c.amax)) hit = 1'b0;
		if (thr_c.tlim != '0 && tilt_q > thr_c.tlim) hit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			seeded_q  <= '0;
			div_cnt_q <= '0;
			cls_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (samp.valid) begin
						if ({1'b0, samp.channel_index} < cnt_q) state_q <= S_MUL1;
						else state_q <= S_RDP;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_UPD;
				S_UPD: begin
					seeded_q[ch_q] <= 1'b1;
					state_q <= S_RDP;
				end
				S_RDP: state_q <= S_RDA;
				S_RDA: state_q <= S_NUM;
				S_NUM: begin
					cls_q <= '0;
					state_q <= dsel_q[DSEL_RATIO] ? S_DSET : S_CLS;
				end
				S_DSET: begin
					div_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(DIV_STEPS - 1)) state_q <= S_CLS;
				end
				S_CLS: begin
					cls_q <= cls_q + 2'd1;
					if (hit || cls_q == 2'd3) state_q <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ch_q       <= samp.channel_index[IW-1:0];
				use_q      <= {1'b0, samp.channel_index} < cnt_q;
				smp_q      <= samp.sample_value & SmpMask;
				tilt_q     <= samp.tilt_magnitude;
				smoothed_q <= '0;
				colour_q   <= COL_UNKNOWN;
			end
			S_MUL1: prod_q <= mul_p[27:0];
			S_MUL2: begin
				acc_q  <= prod_q;
				prod_q <= mul_p[27:0];
			end
			S_UPD: smoothed_q <= rnd_avg(new_avg);
			S_RDA: prim_q <= seeded_q[pidx] ? rnd_avg(rd_q) : '0;
			S_NUM: begin
				aux_q  <= seeded_q[aidx] ? rnd_avg(rd_q) : '0;
				prod_q <= mul_p[27:0];
			end
			S_DSET: begin
				div_q <= aux_nz;
				dq_q  <= div_num[28:8];
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? VAL_W'(div_sh - {1'b0, div_q}) : div_sh[VAL_W-1:0];
				dq_q  <= {dq_q[QUO_W-2:0], div_ge};
			end
			S_CLS: begin
				if (hit) colour_q <= COL_BLACK + COL_W'(cls_q);
			end
			default: ;
		endcase
	end

	assign samp.ready         = (state_q == S_IDLE);
	assign res.valid          = (state_q == S_OUT);
	assign res.smoothed_value = smoothed_q;
	assign res.floor_colour   = colour_q;

	`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_ready_no_result, samp.ready, !res.valid)
	`ASSERT_IMPLIES(a_colour_range, res.valid, res.floor_colour <= COL_SILVER)
	`ASSERT_IMPLIES(a_unused_zero, res.valid && !use_q, res.smoothed_value == '0)
	`ASSERT_NEXT(a_seed_set, state_q == S_UPD, seeded_q[ch_q])
	`ASSERT_IMPLIES(a_div_ratio_only, state_q == S_DIV, dsel_q[DSEL_RATIO])

endmodule
